### sv/scba_pkg.sv
// Shared types, constants and helpers for the size class block allocator.
// No dependencies; size_class_block_allocator_top imports this package.
package scba_pkg;

    localparam int CLASS_SLOTS     = 6;
    localparam int DEF_MAX_PAGES   = 16;
    localparam int DEF_PAGE_BYTES  = 4096;
    localparam int DEF_CLASS_COUNT = 6;
    localparam int BLOCKS_MAX      = 256;
    localparam int FRAME_W         = 52;
    localparam int ADDR_W          = 64;
    localparam int SIZE_W          = 32;
    localparam int BYTES_OUT_W     = 19;
    localparam int MIN_SHIFT       = 4;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_ZERO     = 3'd1;
    localparam logic [2:0] ST_TOO_BIG  = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_NO_PAGE  = 3'd4;
    localparam logic [2:0] ST_DBL_FREE = 3'd5;
    localparam logic [2:0] ST_MISALIGN = 3'd6;
    localparam logic [2:0] ST_NOT_FOUND = 3'd7;

    typedef struct packed {
        logic                   command;
        logic [SIZE_W-1:0]      request_size;
        logic [ADDR_W-1:0]      block_address;
        logic [FRAME_W-1:0]     fresh_page_frame;
        logic                   fresh_page_valid;
    } scba_req_t;

    typedef struct packed {
        logic [ADDR_W-1:0]      result_address;
        logic [2:0]             status;
        logic [2:0]             blk_class;
        logic                   page_taken;
        logic [BYTES_OUT_W-1:0] used_bytes;
        logic [BYTES_OUT_W-1:0] peak_bytes;
    } scba_rsp_t;

    // log2 of the block size of a class
    function automatic logic [3:0] class_shift(input logic [2:0] c);
        return 4'(MIN_SHIFT) + {1'b0, c};
    endfunction

    // free bits of one 64-bit bitmap word of a freshly carved page: blocks 1 to n-1
    function automatic logic [63:0] carve_mask(input logic [1:0] w, input logic [8:0] n);
        logic [63:0] m;
        logic [8:0]  idx;
        m = '0;
        for (int j = 0; j < 64; j++)
        begin
            idx  = {1'b0, w, 6'(j)};
            m[j] = (idx != 9'd0) && (idx < n);
        end
        return m;
    endfunction

endpackage

### sv/size_class_block_allocator_top.sv
// Size class block allocator: six LIFO free stacks over carved pages.
// Depends on scba_pkg and scba_ram (page frame table, free bitmap, free stacks).
//
//   channel | signals                    | beat
//   req     | req_valid, req_stall, req  | one command: allocate or free
//   rsp     | rsp_valid, rsp_stall, rsp  | one result per command
//
// An allocate from a non-empty stack pops it; a carve pushes up to 255 blocks,
// one at a time, through the single stack write port.
// A free walks carved pages in class then slot order, each page through the
// frame table read and the base multiply.
// Reset clears counters and control only; the memories need no clearing pass.
// A result stalled on rsp does not block acceptance of the next command.
module size_class_block_allocator_top
    import scba_pkg::*;
#(
    parameter int MAX_PAGES   = scba_pkg::DEF_MAX_PAGES,
    parameter int PAGE_BYTES  = scba_pkg::DEF_PAGE_BYTES,
    parameter int CLASS_COUNT = scba_pkg::DEF_CLASS_COUNT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  scba_pkg::scba_req_t  req,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output scba_pkg::scba_rsp_t  rsp
);

    localparam int SLOT_W    = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int PCNT_W    = $clog2(MAX_PAGES + 1);
    localparam int SD        = MAX_PAGES * BLOCKS_MAX;
    localparam int FILL_W    = $clog2(SD + 1);
    localparam int PAGES_TOT = CLASS_SLOTS * MAX_PAGES;
    localparam int FRAME_AW  = $clog2(PAGES_TOT);
    localparam int BM_DEPTH  = PAGES_TOT * 4;
    localparam int BM_AW     = $clog2(BM_DEPTH);
    localparam int STK_DEPTH = CLASS_SLOTS * SD;
    localparam int STK_AW    = $clog2(STK_DEPTH);
    localparam int ENTRY_W   = SLOT_W + 8;
    localparam int USED_W    = $clog2(CLASS_SLOTS * MAX_PAGES * PAGE_BYTES + 1);
    localparam int OFF_W     = $clog2(PAGE_BYTES);
    localparam int PB_W      = $clog2(PAGE_BYTES + 1);
    localparam int PLO_W     = 26 + PB_W;

    localparam logic [3:0] S_IDLE       = 4'd0;
    localparam logic [3:0] S_DEC        = 4'd1;
    localparam logic [3:0] S_ALLOC      = 4'd2;
    localparam logic [3:0] S_CARVE_BM   = 4'd3;
    localparam logic [3:0] S_CARVE_PUSH = 4'd4;
    localparam logic [3:0] S_POP_RD     = 4'd5;
    localparam logic [3:0] S_MUL        = 4'd6;
    localparam logic [3:0] S_BASE       = 4'd7;
    localparam logic [3:0] S_CHK        = 4'd8;
    localparam logic [3:0] S_FREE_NEXT  = 4'd9;
    localparam logic [3:0] S_FREE_BM    = 4'd10;
    localparam logic [3:0] S_DONE       = 4'd11;

    localparam logic [1:0] K_POP   = 2'd0;
    localparam logic [1:0] K_CARVE = 2'd1;
    localparam logic [1:0] K_FREE  = 2'd2;

    logic [3:0]          state_reg, state_next;
    logic [1:0]          kind_reg, kind_next;
    scba_req_t           item_reg, item_next;
    logic [2:0]          class_reg, class_next;
    logic [PCNT_W-1:0]   slot_reg, slot_next;
    logic [8:0]          idx_reg, idx_next;
    logic [1:0]          word_reg, word_next;
    logic [PLO_W-1:0]    plo_reg, plo_next;
    logic [PLO_W-1:0]    phi_reg, phi_next;
    logic [ADDR_W-1:0]   base_reg, base_next;
    logic [ADDR_W-1:0]   raddr_reg, raddr_next;
    logic [2:0]          status_reg, status_next;
    logic [2:0]          cls_out_reg, cls_out_next;
    logic                taken_reg, taken_next;
    logic [USED_W-1:0]   used_reg, used_next;
    logic [USED_W-1:0]   peak_reg, peak_next;
    logic [PCNT_W-1:0]   pages_reg [CLASS_SLOTS];
    logic [PCNT_W-1:0]   pages_next [CLASS_SLOTS];
    logic [FILL_W-1:0]   fill_reg [CLASS_SLOTS];
    logic [FILL_W-1:0]   fill_next [CLASS_SLOTS];
    logic                rsp_valid_reg, rsp_valid_next;
    scba_rsp_t           rsp_reg, rsp_next;

    // memory ports
    logic                frm_we;
    logic [FRAME_AW-1:0] frm_waddr, frm_raddr;
    logic [FRAME_W-1:0]  frm_wdata, frm_rdata;
    logic                bm_we;
    logic [BM_AW-1:0]    bm_waddr, bm_raddr;
    logic [63:0]         bm_wdata, bm_rdata;
    logic                stk_we;
    logic [STK_AW-1:0]   stk_waddr, stk_raddr;
    logic [ENTRY_W-1:0]  stk_wdata, stk_rdata;

    scba_ram #(.WIDTH(FRAME_W), .DEPTH(PAGES_TOT)) u_frame_ram (
        .clk(clk), .wr_en(frm_we), .wr_addr(frm_waddr), .wr_data(frm_wdata),
        .rd_addr(frm_raddr), .rd_data(frm_rdata)
    );

    scba_ram #(.WIDTH(64), .DEPTH(BM_DEPTH)) u_bitmap_ram (
        .clk(clk), .wr_en(bm_we), .wr_addr(bm_waddr), .wr_data(bm_wdata),
        .rd_addr(bm_raddr), .rd_data(bm_rdata)
    );

    scba_ram #(.WIDTH(ENTRY_W), .DEPTH(STK_DEPTH)) u_stack_ram (
        .clk(clk), .wr_en(stk_we), .wr_addr(stk_waddr), .wr_data(stk_wdata),
        .rd_addr(stk_raddr), .rd_data(stk_rdata)
    );

    // derived per-class values
    logic [2:0]          pick_cls;
    logic                pick_ok;
    logic [3:0]          cur_shift;
    logic [USED_W-1:0]   blk_cur;
    logic [PB_W-1:0]     n_raw;
    logic [8:0]          n_cur;
    logic [FRAME_AW-1:0] pidx_cur, pidx_pop;
    logic [STK_AW-1:0]   stk_base;
    logic [FILL_W-1:0]   fill_cur;
    logic [PCNT_W-1:0]   pages_cur;
    logic [SLOT_W-1:0]   pop_slot;
    logic [7:0]          pop_idx;
    logic [FRAME_W-1:0]  mul_op;
    logic [ADDR_W-1:0]   diff;
    logic                hit;
    logic [OFF_W-1:0]    off, i_full, blk_mask;
    logic                misaligned;
    logic [USED_W:0]     used_sum;

    always_comb
    begin
        pick_cls = '0;
        pick_ok  = 1'b0;
        for (int k = CLASS_SLOTS - 1; k >= 0; k--)
        begin
            if (k < CLASS_COUNT && item_reg.request_size <= (32'd16 << k))
            begin
                pick_cls = 3'(k);
                pick_ok  = 1'b1;
            end
        end
    end

    assign cur_shift = class_shift(class_reg);
    assign blk_cur   = USED_W'(1) << cur_shift;
    assign n_raw     = PB_W'(PAGE_BYTES) >> cur_shift;
    assign n_cur     = (n_raw > PB_W'(BLOCKS_MAX)) ? 9'(BLOCKS_MAX) : 9'(n_raw);
    assign pidx_cur  = FRAME_AW'(class_reg) * FRAME_AW'(MAX_PAGES)
                     + FRAME_AW'(slot_reg[SLOT_W-1:0]);
    assign pop_slot  = stk_rdata[ENTRY_W-1:8];
    assign pop_idx   = stk_rdata[7:0];
    assign pidx_pop  = FRAME_AW'(class_reg) * FRAME_AW'(MAX_PAGES) + FRAME_AW'(pop_slot);
    assign stk_base  = STK_AW'(class_reg) * STK_AW'(SD);
    assign fill_cur  = fill_reg[class_reg];
    assign pages_cur = pages_reg[class_reg];
    assign mul_op    = (kind_reg == K_CARVE) ? item_reg.fresh_page_frame : frm_rdata;

    assign diff       = item_reg.block_address - base_reg;
    assign hit        = (item_reg.block_address >= base_reg) && (diff < ADDR_W'(PAGE_BYTES));
    assign off        = diff[OFF_W-1:0];
    assign i_full     = off >> cur_shift;
    assign blk_mask   = (OFF_W'(1) << cur_shift) - OFF_W'(1);
    assign misaligned = ((off & blk_mask) != '0) || (i_full >= OFF_W'(n_cur));
    assign used_sum   = {1'b0, used_reg} + {1'b0, blk_cur};

    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        item_next      = item_reg;
        class_next     = class_reg;
        slot_next      = slot_reg;
        idx_next       = idx_reg;
        word_next      = word_reg;
        plo_next       = plo_reg;
        phi_next       = phi_reg;
        base_next      = base_reg;
        raddr_next     = raddr_reg;
        status_next    = status_reg;
        cls_out_next   = cls_out_reg;
        taken_next     = taken_reg;
        used_next      = used_reg;
        peak_next      = peak_reg;
        pages_next     = pages_reg;
        fill_next      = fill_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;

        frm_we    = 1'b0;
        frm_waddr = pidx_cur;
        frm_wdata = item_reg.fresh_page_frame;
        frm_raddr = pidx_cur;
        bm_we     = 1'b0;
        bm_waddr  = {pidx_cur, idx_reg[7:6]};
        bm_wdata  = bm_rdata;
        bm_raddr  = {pidx_cur, idx_reg[7:6]};
        stk_we    = 1'b0;
        stk_waddr = stk_base + STK_AW'(fill_cur);
        stk_wdata = {slot_reg[SLOT_W-1:0], idx_reg[7:0]};
        stk_raddr = stk_base + STK_AW'(fill_cur - FILL_W'(1));

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    item_next    = req;
                    status_next  = ST_OK;
                    cls_out_next = '0;
                    taken_next   = 1'b0;
                    raddr_next   = '0;
                    state_next   = S_DEC;
                end
            end
            S_DEC:
            begin
                if (item_reg.command == CMD_FREE)
                begin
                    kind_next   = K_FREE;
                    class_next  = '0;
                    slot_next   = '0;
                    status_next = ST_NOT_FOUND;
                    state_next  = S_FREE_NEXT;
                end
                else if (item_reg.request_size == '0)
                begin
                    status_next = ST_ZERO;
                    state_next  = S_DONE;
                end
                else if (!pick_ok)
                begin
                    status_next = ST_TOO_BIG;
                    state_next  = S_DONE;
                end
                else
                begin
                    class_next   = pick_cls;
                    cls_out_next = pick_cls;
                    state_next   = S_ALLOC;
                end
            end
            S_ALLOC:
            begin
                if (fill_cur != '0)
                begin
                    // pop: stack read issued here
                    fill_next[class_reg] = fill_cur - FILL_W'(1);
                    kind_next            = K_POP;
                    state_next           = S_POP_RD;
                end
                else if (pages_cur >= PCNT_W'(MAX_PAGES))
                begin
                    status_next = ST_FULL;
                    state_next  = S_DONE;
                end
                else if (!item_reg.fresh_page_valid)
                begin
                    status_next = ST_NO_PAGE;
                    state_next  = S_DONE;
                end
                else
                begin
                    kind_next  = K_CARVE;
                    slot_next  = pages_cur;
                    word_next  = '0;
                    state_next = S_CARVE_BM;
                end
            end
            S_CARVE_BM:
            begin
                frm_we    = (word_reg == 2'd0);
                bm_we     = 1'b1;
                bm_waddr  = {pidx_cur, word_reg};
                bm_wdata  = carve_mask(word_reg, n_cur);
                word_next = word_reg + 2'd1;
                if (word_reg == 2'd3)
                begin
                    idx_next   = 9'd1;
                    state_next = S_CARVE_PUSH;
                end
            end
            S_CARVE_PUSH:
            begin
                if (idx_reg < n_cur)
                begin
                    if (fill_cur < FILL_W'(SD))
                    begin
                        stk_we               = 1'b1;
                        fill_next[class_reg] = fill_cur + FILL_W'(1);
                    end
                    idx_next = idx_reg + 9'd1;
                end
                else
                begin
                    pages_next[class_reg] = pages_cur + PCNT_W'(1);
                    taken_next            = 1'b1;
                    idx_next              = '0;
                    state_next            = S_MUL;
                end
            end
            S_POP_RD:
            begin
                slot_next  = PCNT_W'(pop_slot);
                idx_next   = {1'b0, pop_idx};
                frm_raddr  = pidx_pop;
                bm_raddr   = {pidx_pop, pop_idx[7:6]};
                state_next = S_MUL;
            end
            S_MUL:
            begin
                plo_next = PLO_W'(mul_op[25:0]) * PLO_W'(PAGE_BYTES);
                phi_next = PLO_W'(mul_op[51:26]) * PLO_W'(PAGE_BYTES);
                if (kind_reg == K_POP)
                begin
                    bm_we    = 1'b1;
                    bm_wdata = bm_rdata & ~(64'd1 << idx_reg[5:0]);
                end
                state_next = S_BASE;
            end
            S_BASE:
            begin
                base_next  = ADDR_W'(plo_reg) + (ADDR_W'(phi_reg) << 26);
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (kind_reg == K_FREE)
                begin
                    if (hit)
                    begin
                        cls_out_next = class_reg;
                        idx_next     = 9'(i_full);
                        if (misaligned)
                        begin
                            status_next = ST_MISALIGN;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            bm_raddr   = {pidx_cur, i_full[7:6]};
                            state_next = S_FREE_BM;
                        end
                    end
                    else
                    begin
                        slot_next  = slot_reg + PCNT_W'(1);
                        state_next = S_FREE_NEXT;
                    end
                end
                else
                begin
                    raddr_next = base_reg + (ADDR_W'(idx_reg[7:0]) << cur_shift);
                    used_next  = used_sum[USED_W-1:0];
                    if (used_sum[USED_W-1:0] > peak_reg)
                    begin
                        peak_next = used_sum[USED_W-1:0];
                    end
                    state_next = S_DONE;
                end
            end
            S_FREE_NEXT:
            begin
                if (class_reg >= 3'(CLASS_COUNT))
                begin
                    cls_out_next = '0;
                    state_next   = S_DONE;
                end
                else if (slot_reg >= pages_cur)
                begin
                    class_next = class_reg + 3'd1;
                    slot_next  = '0;
                end
                else
                begin
                    state_next = S_MUL;
                end
            end
            S_FREE_BM:
            begin
                if (bm_rdata[idx_reg[5:0]])
                begin
                    status_next = ST_DBL_FREE;
                end
                else
                begin
                    status_next = ST_OK;
                    bm_we       = 1'b1;
                    bm_wdata    = bm_rdata | (64'd1 << idx_reg[5:0]);
                    if (fill_cur < FILL_W'(SD))
                    begin
                        stk_we               = 1'b1;
                        fill_next[class_reg] = fill_cur + FILL_W'(1);
                    end
                    used_next = (used_reg >= blk_cur) ? used_reg - blk_cur : '0;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // hold until the output register is free
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next.result_address = raddr_reg;
                    rsp_next.status         = status_reg;
                    rsp_next.blk_class      = cls_out_reg;
                    rsp_next.page_taken     = taken_reg;
                    rsp_next.used_bytes     = BYTES_OUT_W'(used_reg);
                    rsp_next.peak_bytes     = BYTES_OUT_W'(peak_reg);
                    rsp_valid_next          = 1'b1;
                    state_next              = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            kind_reg      <= K_POP;
            used_reg      <= '0;
            peak_reg      <= '0;
            rsp_valid_reg <= 1'b0;
            for (int k = 0; k < CLASS_SLOTS; k++)
            begin
                pages_reg[k] <= '0;
                fill_reg[k]  <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            kind_reg      <= kind_next;
            used_reg      <= used_next;
            peak_reg      <= peak_next;
            rsp_valid_reg <= rsp_valid_next;
            pages_reg     <= pages_next;
            fill_reg      <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg    <= item_next;
        class_reg   <= class_next;
        slot_reg    <= slot_next;
        idx_reg     <= idx_next;
        word_reg    <= word_next;
        plo_reg     <= plo_next;
        phi_reg     <= phi_next;
        base_reg    <= base_next;
        raddr_reg   <= raddr_next;
        status_reg  <= status_next;
        cls_out_reg <= cls_out_next;
        taken_reg   <= taken_next;
        rsp_reg     <= rsp_next;
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef ASSERT_OFF
    a_peak_covers_used: assert property (@(posedge clk) disable iff (!rst_n)
        peak_reg >= used_reg)
        else $error("peak byte count below used byte count");

    a_push_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CARVE_PUSH) && (idx_reg < n_cur) |-> fill_cur < FILL_W'(SD))
        else $error("free stack overflow during carve");

    a_pages_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ALLOC) |-> pages_cur <= PCNT_W'(MAX_PAGES))
        else $error("page count past limit");

    a_taken_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_reg.page_taken |-> rsp_reg.status == ST_OK)
        else $error("page taken on a failed allocate");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_POP_RD) |-> $past(fill_cur) != '0)
        else $error("pop from an empty free stack");
`endif

endmodule

### sv/scba_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module scba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
